// ===== src/swcfd_pkg.sv =====
package swcfd_pkg;

    // Frame kinds as they arrive on the input side.
    typedef enum logic [1:0] {
        KIND_TH    = 2'd0,
        KIND_READY = 2'd1,
        KIND_CO2   = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CRC_BAD  = 2'd1,
        ST_NO_DATA  = 2'd2,
        ST_RESERVED = 2'd3
    } t_status;

    // One completed frame, handed from the front end to the back end.
    typedef struct packed {
        t_status     status;
        t_kind       kind;
        logic [15:0] first_word;
        logic [15:0] second_word;
    } t_frame_req;

    // Fill state of the request queue.
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_queue_status;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [3:0]  POS_IDLE    = 4'd15;
    localparam logic [15:0] READY_MASK  = 16'h07FF;
    localparam logic [30:0] TEMP_SCALE  = 31'd17500;
    localparam logic [29:0] HUM_SCALE   = 30'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [16:0] WORD_MAX    = 17'd65535;

    // CRC-8 update over one byte, MSB first, no reflection.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/swcfd_front.sv =====
module swcfd_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic [1:0]              i_frame_kind,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_first_byte,
    input  logic                    i_queue_full,
    output logic                    o_in_stall,
    output logic                    o_push,
    output swcfd_pkg::t_frame_req   o_req
);

    logic [7:0]             r_crc, n_crc;
    logic [3:0]             r_pos, n_pos;
    swcfd_pkg::t_kind       r_kind, n_kind;
    logic [7:0]             r_hold, n_hold;
    logic [15:0]            r_first, n_first;
    logic [15:0]            r_second, n_second;
    logic                   r_failed, n_failed;
    logic [3:0]             w_last_pos;
    logic                   w_accept;

    // A byte is taken whenever the queue has room for a possible result.
    assign o_in_stall = i_queue_full;
    assign w_accept   = i_in_valid && !i_queue_full;

    // Frame tracking: start handling, CRC per word, word capture, end of frame.
    always_comb begin
        n_crc      = r_crc;
        n_pos      = r_pos;
        n_kind     = r_kind;
        n_hold     = r_hold;
        n_first    = r_first;
        n_second   = r_second;
        n_failed   = r_failed;
        w_last_pos = 4'd8;
        o_push     = 1'b0;
        o_req      = '0;

        if (w_accept) begin
            if (i_first_byte) begin
                n_crc    = swcfd_pkg::CRC_INIT;
                n_failed = 1'b0;
                n_kind   = swcfd_pkg::t_kind'(i_frame_kind);
                n_pos    = (n_kind == swcfd_pkg::KIND_NONE) ? swcfd_pkg::POS_IDLE : 4'd0;
            end

            unique case (n_kind)
                swcfd_pkg::KIND_TH:    w_last_pos = 4'd5;
                swcfd_pkg::KIND_READY: w_last_pos = 4'd2;
                swcfd_pkg::KIND_CO2:   w_last_pos = 4'd8;
                swcfd_pkg::KIND_NONE:  w_last_pos = 4'd8;
            endcase

            if (n_pos != swcfd_pkg::POS_IDLE && n_kind != swcfd_pkg::KIND_NONE) begin
                // Each word is high byte, low byte, then its CRC byte.
                unique case (n_pos)
                    4'd0, 4'd3, 4'd6: begin
                        n_hold = i_data_byte;
                        n_crc  = swcfd_pkg::crc8_byte(n_crc, i_data_byte);
                    end
                    4'd1, 4'd4, 4'd7: begin
                        n_crc = swcfd_pkg::crc8_byte(n_crc, i_data_byte);
                        if (n_pos == 4'd1) begin
                            n_first = {r_hold, i_data_byte};
                        end
                        if (n_pos == 4'd4) begin
                            n_second = {r_hold, i_data_byte};
                        end
                    end
                    default: begin
                        if (n_crc != i_data_byte) begin
                            n_failed = 1'b1;
                        end
                        n_crc = swcfd_pkg::CRC_INIT;
                    end
                endcase

                if (n_pos == w_last_pos) begin
                    n_pos             = swcfd_pkg::POS_IDLE;
                    o_push            = 1'b1;
                    o_req.kind        = n_kind;
                    o_req.first_word  = n_first;
                    o_req.second_word = n_second;
                    priority if (n_failed) begin
                        o_req.status = swcfd_pkg::ST_CRC_BAD;
                    end else if (n_kind == swcfd_pkg::KIND_READY &&
                                 (n_first & swcfd_pkg::READY_MASK) == 16'd0) begin
                        o_req.status = swcfd_pkg::ST_NO_DATA;
                    end else begin
                        o_req.status = swcfd_pkg::ST_OK;
                    end
                end else begin
                    n_pos = n_pos + 4'd1;
                end
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= swcfd_pkg::CRC_INIT;
            r_pos    <= 4'd0;
            r_kind   <= swcfd_pkg::KIND_TH;
            r_hold   <= 8'd0;
            r_first  <= 16'd0;
            r_second <= 16'd0;
            r_failed <= 1'b0;
        end else begin
            r_crc    <= n_crc;
            r_pos    <= n_pos;
            r_kind   <= n_kind;
            r_hold   <= n_hold;
            r_first  <= n_first;
            r_second <= n_second;
            r_failed <= n_failed;
        end
    end

endmodule

// ===== src/swcfd_queue.sv =====
module swcfd_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  swcfd_pkg::t_frame_req     i_req,
    input  logic                      i_pop,
    output swcfd_pkg::t_frame_req     o_head,
    output swcfd_pkg::t_queue_status  o_status
);

    swcfd_pkg::t_frame_req  r_mem [2];
    logic                   r_wr_ptr;
    logic                   r_rd_ptr;
    logic [1:0]             r_count;

    assign o_head             = r_mem[r_rd_ptr];
    assign o_status.full      = (r_count == 2'd2);
    assign o_status.not_empty = (r_count != 2'd0);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== src/swcfd_back.sv =====
module swcfd_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_head_valid,
    input  swcfd_pkg::t_frame_req   i_head,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_frame_status,
    output logic [1:0]              o_kind_done,
    output logic signed [14:0]      o_temperature_centi,
    output logic [13:0]             o_humidity_centi,
    output logic [15:0]             o_co2_ppm
);

    logic               r_s1_valid;
    logic [30:0]        r_s1_temp_prod;
    logic [29:0]        r_s1_hum_prod;
    logic [1:0]         r_s1_status;
    logic [1:0]         r_s1_kind;
    logic [15:0]        r_s1_co2;
    logic               r_s1_scaled;

    logic               r_out_valid;
    logic [1:0]         r_status;
    logic [1:0]         r_kind;
    logic [14:0]        r_temp;
    logic [13:0]        r_hum;
    logic [15:0]        r_co2;

    logic               w_s2_ready;
    logic               w_s1_ready;
    logic               w_ok;
    logic [14:0]        w_temp_q;
    logic [16:0]        w_temp_rem;
    logic [14:0]        w_temp_q_fix;
    logic [13:0]        w_hum_q;
    logic [16:0]        w_hum_rem;
    logic [13:0]        w_hum_q_fix;

    // Stage handshake: each stage moves when the one after it has room.
    assign w_s2_ready = !r_out_valid || !i_out_stall;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign o_pop      = i_head_valid && w_s1_ready;
    assign w_ok       = (i_head.status == swcfd_pkg::ST_OK);

    // Stage 1: scale the raw words by the constant numerators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_head_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_temp_prod <= swcfd_pkg::TEMP_SCALE * {15'd0, i_head.first_word};
            r_s1_hum_prod  <= swcfd_pkg::HUM_SCALE * {14'd0, i_head.second_word};
            r_s1_status    <= i_head.status;
            r_s1_kind      <= i_head.kind;
            r_s1_co2       <= (w_ok && i_head.kind == swcfd_pkg::KIND_CO2) ?
                              i_head.first_word : 16'd0;
            r_s1_scaled    <= w_ok && i_head.kind == swcfd_pkg::KIND_TH;
        end
    end

    // Stage 2: divide by 65535 as a shift by 16 plus one correction step.
    always_comb begin
        w_temp_q     = r_s1_temp_prod[30:16];
        w_temp_rem   = {1'b0, r_s1_temp_prod[15:0]} + {2'd0, w_temp_q};
        w_temp_q_fix = (w_temp_rem >= swcfd_pkg::WORD_MAX) ? w_temp_q + 15'd1 : w_temp_q;
        w_hum_q      = r_s1_hum_prod[29:16];
        w_hum_rem    = {1'b0, r_s1_hum_prod[15:0]} + {3'd0, w_hum_q};
        w_hum_q_fix  = (w_hum_rem >= swcfd_pkg::WORD_MAX) ? w_hum_q + 14'd1 : w_hum_q;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_s2_ready) begin
            r_status <= r_s1_status;
            r_kind   <= r_s1_kind;
            r_temp   <= r_s1_scaled ? w_temp_q_fix - swcfd_pkg::TEMP_OFFSET : 15'd0;
            r_hum    <= r_s1_scaled ? w_hum_q_fix : 14'd0;
            r_co2    <= r_s1_co2;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_frame_status      = r_status;
    assign o_kind_done         = r_kind;
    assign o_temperature_centi = signed'(r_temp);
    assign o_humidity_centi    = r_hum;
    assign o_co2_ppm           = r_co2;

endmodule

// ===== src/sensor_word_crc_frame_decoder.sv =====
// Sensor frame decoder: takes received sensor bytes one per request and checks each
// 16-bit word against its trailing CRC-8 byte (polynomial 0x31, start value 0xFF). A
// request with first_byte set opens a frame of the given kind: 6 bytes of
// temperature/humidity, 3 bytes of data-ready status or 9 bytes of CO2 measurement;
// kind 3 opens nothing. On the last byte of a frame one result request comes out with
// the status, the frame kind and the scaled values (zero where they do not apply).
// Bytes are accepted at one per cycle while the input is not stalled; the byte decoder
// updates the CRC within the cycle. After the edge that takes its last byte, a result
// waits at the head of the two-entry result queue while the constant multiplies are
// formed, then sits in the product register while the divide-by-65535 correction is
// applied on the way into the output register. Output stalls hold results back. Input
// stalls only when two finished frames wait in the queue.
module sensor_word_crc_frame_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_frame_kind,
    input  logic [7:0]          i_data_byte,
    input  logic                i_first_byte,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_frame_status,
    output logic [1:0]          o_kind_done,
    output logic signed [14:0]  o_temperature_centi,
    output logic [13:0]         o_humidity_centi,
    output logic [15:0]         o_co2_ppm
);

    logic                       w_push;
    logic                       w_pop;
    swcfd_pkg::t_frame_req      w_req;
    swcfd_pkg::t_frame_req      w_head;
    swcfd_pkg::t_queue_status   w_q_status;

    // Byte decoder.
    swcfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_frame_kind (i_frame_kind),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_queue_full (w_q_status.full),
        .o_in_stall   (o_in_stall),
        .o_push       (w_push),
        .o_req        (w_req)
    );

    // Finished frames wait here for the scaling pipeline.
    swcfd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_req    (w_req),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // Scaling pipeline and output register.
    swcfd_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head_valid        (w_q_status.not_empty),
        .i_head              (w_head),
        .o_pop               (w_pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_frame_status      (o_frame_status),
        .o_kind_done         (o_kind_done),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi),
        .o_co2_ppm           (o_co2_ppm)
    );

    // A frame opened with kind 3 never produces a result on its first byte.
    a_no_push_kind_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_first_byte &&
        i_frame_kind == swcfd_pkg::KIND_NONE |-> !w_push)
        else $error("result pushed for an ignored frame kind");

    // Measured values are zero unless the frame completed cleanly.
    a_values_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_status != swcfd_pkg::ST_OK |->
        o_temperature_centi == 15'sd0 && o_humidity_centi == 14'd0 && o_co2_ppm == 16'd0)
        else $error("nonzero values with a failed status");

    // No-data status only comes from data-ready frames.
    a_no_data_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_status == swcfd_pkg::ST_NO_DATA |->
        o_kind_done == swcfd_pkg::KIND_READY)
        else $error("no-data status on a frame of another kind");

    // The queue is never popped while empty.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_status.not_empty)
        else $error("pop from an empty result queue");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// CRC-8 over one byte, MSB first, polynomial from the package; the caller passes the start value.
function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] reg8;
    reg8 = acc ^ data;
    repeat (8) begin
        reg8 = reg8[7] ? ((reg8 << 1) ^ swcfd_pkg::CRC_POLY) : (reg8 << 1);
    end
    return reg8;
endfunction

// Number of bytes in a frame of the given kind.
function automatic int frame_bytes(input swcfd_pkg::t_kind kind);
    case (kind)
        swcfd_pkg::KIND_TH:    return 6;
        swcfd_pkg::KIND_READY: return 3;
        default:               return 9;
    endcase
endfunction

typedef struct {
    swcfd_pkg::t_status status;
    swcfd_pkg::t_kind   kind;
    logic signed [14:0] temp;
    logic [13:0]        hum;
    logic [15:0]        co2;
} t_frame_result;

// Tracks the frame decode state and holds the results that completed frames must produce.
class frame_scoreboard;
    logic [7:0]       crc_acc;
    logic [3:0]       byte_pos;
    swcfd_pkg::t_kind open_kind;
    logic [7:0]       high_hold;
    logic [15:0]      word_a;
    logic [15:0]      word_b;
    bit               crc_bad;
    t_frame_result    pending[$];
    int               fail_count;

    function new();
        crc_acc    = swcfd_pkg::CRC_INIT;
        byte_pos   = 4'd0;
        open_kind  = swcfd_pkg::KIND_TH;
        high_hold  = 8'd0;
        word_a     = 16'd0;
        word_b     = 16'd0;
        crc_bad    = 1'b0;
        fail_count = 0;
    endfunction

    // Advance the decode state by one accepted byte request.
    function void note_byte(input swcfd_pkg::t_kind kind, input logic [7:0] data,
                            input logic first);
        t_frame_result res;
        int unsigned   quotient;
        if (first) begin
            crc_acc   = swcfd_pkg::CRC_INIT;
            crc_bad   = 1'b0;
            open_kind = kind;
            byte_pos  = (kind == swcfd_pkg::KIND_NONE) ? swcfd_pkg::POS_IDLE : 4'd0;
        end
        if (byte_pos == swcfd_pkg::POS_IDLE || open_kind == swcfd_pkg::KIND_NONE) begin
            return;
        end

        // High byte, low byte, then the CRC byte of each word.
        case (byte_pos % 3)
            0: begin
                high_hold = data;
                crc_acc   = crc8_step(crc_acc, data);
            end
            1: begin
                crc_acc = crc8_step(crc_acc, data);
                if (byte_pos / 3 == 0) begin
                    word_a = {high_hold, data};
                end else if (byte_pos / 3 == 1) begin
                    word_b = {high_hold, data};
                end
            end
            default: begin
                if (crc_acc != data) begin
                    crc_bad = 1'b1;
                end
                crc_acc = swcfd_pkg::CRC_INIT;
            end
        endcase

        if (int'(byte_pos) + 1 < frame_bytes(open_kind)) begin
            byte_pos = byte_pos + 4'd1;
            return;
        end

        // Last byte of the frame: build the expected result.
        byte_pos = swcfd_pkg::POS_IDLE;
        res.kind = open_kind;
        res.temp = '0;
        res.hum  = '0;
        res.co2  = '0;
        if (crc_bad) begin
            res.status = swcfd_pkg::ST_CRC_BAD;
        end else if (open_kind == swcfd_pkg::KIND_READY &&
                     (word_a & swcfd_pkg::READY_MASK) == 16'd0) begin
            res.status = swcfd_pkg::ST_NO_DATA;
        end else begin
            res.status = swcfd_pkg::ST_OK;
        end
        if (res.status == swcfd_pkg::ST_OK && open_kind == swcfd_pkg::KIND_TH) begin
            quotient = (swcfd_pkg::TEMP_SCALE * word_a) / swcfd_pkg::WORD_MAX;
            res.temp = 15'(quotient) - swcfd_pkg::TEMP_OFFSET;
            quotient = (swcfd_pkg::HUM_SCALE * word_b) / swcfd_pkg::WORD_MAX;
            res.hum  = 14'(quotient);
        end
        if (res.status == swcfd_pkg::ST_OK && open_kind == swcfd_pkg::KIND_CO2) begin
            res.co2 = word_a;
        end
        pending.push_back(res);
    endfunction

    // Compare one accepted result request with the oldest pending frame result.
    function void check_result(input logic [1:0] status, input logic [1:0] kind,
                               input logic signed [14:0] temp, input logic [13:0] hum,
                               input logic [15:0] co2);
        t_frame_result exp_res;
        if (pending.size() == 0) begin
            $error("result with no frame pending: status %0d kind %0d", status, kind);
            fail_count++;
            return;
        end
        exp_res = pending.pop_front();
        if (status !== exp_res.status) begin
            $error("frame_status: expected %0d, got %0d", exp_res.status, status);
            fail_count++;
        end
        if (kind !== exp_res.kind) begin
            $error("kind_done: expected %0d, got %0d", exp_res.kind, kind);
            fail_count++;
        end
        if (temp !== exp_res.temp) begin
            $error("temperature_centi: expected %0d, got %0d", exp_res.temp, temp);
            fail_count++;
        end
        if (hum !== exp_res.hum) begin
            $error("humidity_centi: expected %0d, got %0d", exp_res.hum, hum);
            fail_count++;
        end
        if (co2 !== exp_res.co2) begin
            $error("co2_ppm: expected %0d, got %0d", exp_res.co2, co2);
            fail_count++;
        end
    endfunction
endclass

module tb_top;

    localparam int RANDOM_BYTES   = 1750;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 3000;

    logic i_clk;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    logic [1:0] in_kind  = 2'd0;
    logic [7:0] in_data  = 8'd0;
    logic in_first  = 1'b0;
    logic out_stall = 1'b0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [1:0]         o_frame_status;
    logic [1:0]         o_kind_done;
    logic signed [14:0] o_temperature_centi;
    logic [13:0]        o_humidity_centi;
    logic [15:0]        o_co2_ppm;

    frame_scoreboard sb = new();
    int burst_left  = 0;
    int bytes_sent  = 0;
    int idle_cycles = 0;
    int stall_span  = 0;
    int stall_mode  = 0;

    sensor_word_crc_frame_decoder u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (o_in_stall),
        .i_frame_kind        (in_kind),
        .i_data_byte         (in_data),
        .i_first_byte        (in_first),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (out_stall),
        .o_frame_status      (o_frame_status),
        .o_kind_done         (o_kind_done),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi),
        .o_co2_ppm           (o_co2_ppm)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Both monitors sample at the clock edge, before the edge updates take effect.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                sb.note_byte(swcfd_pkg::t_kind'(in_kind), in_data, in_first);
            end
            if (o_out_valid && !out_stall) begin
                sb.check_result(o_frame_status, o_kind_done, o_temperature_centi,
                                o_humidity_centi, o_co2_ppm);
            end
        end
    end

    // Receiver stall pattern: switches between free flow, light, heavy and periodic stalls.
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(64, 256);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_span % 12) < 7);
        endcase
    end

    // Watchdog on cycles in which neither side moves a request.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** sensor_word_crc_frame_decoder: FAILED **");
            $finish;
        end
    end

    // Present one byte request and hold it until accepted; the sender works in bursts.
    task automatic offer_byte(input logic [1:0] kind, input logic [7:0] data, input logic first);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_data  <= data;
        in_first <= first;
        do begin
            @(posedge i_clk);
        end while (!(in_valid && !o_in_stall));
        bytes_sent++;
    endtask

    // Send the first len_used bytes of a frame; a word index in bad_word gets a wrong CRC.
    task automatic send_frame(input swcfd_pkg::t_kind kind, input logic [15:0] wa,
                              input logic [15:0] wb, input logic [15:0] wc,
                              input int bad_word, input int len_used, input bit opener);
        logic [15:0] words[3];
        logic [7:0]  data;
        logic [1:0]  kind_field;
        int          widx;
        words[0] = wa;
        words[1] = wb;
        words[2] = wc;
        for (int i = 0; i < len_used; i++) begin
            widx = i / 3;
            case (i % 3)
                0:       data = words[widx][15:8];
                1:       data = words[widx][7:0];
                default: begin
                    data = crc8_step(crc8_step(swcfd_pkg::CRC_INIT, words[widx][15:8]),
                                     words[widx][7:0]);
                    if (widx == bad_word) begin
                        data = data ^ 8'($urandom_range(1, 255));
                    end
                end
            endcase
            // The kind field only matters on an opening byte.
            kind_field = (i == 0) ? kind : 2'($urandom_range(0, 3));
            offer_byte(kind_field, data, (i == 0) && opener);
        end
    endtask

    // Hold off the sender until every pending frame result has been seen.
    task automatic drain_results();
        in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.pending.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        swcfd_pkg::t_kind kind;
        logic [15:0]      wa;
        int               len;
        int               len_used;
        int               bad_word;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bytes before any opening byte decode as a temperature/humidity frame.
        send_frame(swcfd_pkg::KIND_TH, 16'hFFFF, 16'h0000, 16'h0000, -1, 6, 1'b0);
        send_frame(swcfd_pkg::KIND_TH, 16'h0000, 16'hFFFF, 16'h0000, -1, 6, 1'b1);
        // Status word with no data ready, then the same with a bad CRC, which wins.
        send_frame(swcfd_pkg::KIND_READY, 16'hF800, 16'h0000, 16'h0000, -1, 3, 1'b1);
        send_frame(swcfd_pkg::KIND_READY, 16'h0000, 16'h0000, 16'h0000, 0, 3, 1'b1);
        send_frame(swcfd_pkg::KIND_CO2, 16'hFFFF, 16'h1234, 16'hABCD, -1, 9, 1'b1);
        // A byte after a completed frame is ignored, as is a frame of kind three.
        offer_byte(swcfd_pkg::KIND_CO2, 8'h00, 1'b0);
        offer_byte(swcfd_pkg::KIND_NONE, 8'h5A, 1'b1);
        offer_byte(swcfd_pkg::KIND_TH, 8'hA5, 1'b0);
        drain_results();

        // Random frames: mostly well formed, some with bad CRCs, cut short or with noise.
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 99) < 5) begin
                offer_byte(swcfd_pkg::KIND_NONE, 8'($urandom), 1'b1);
                repeat ($urandom_range(0, 8)) begin
                    offer_byte(2'($urandom_range(0, 3)), 8'($urandom), 1'b0);
                end
            end else begin
                kind = swcfd_pkg::t_kind'($urandom_range(0, 2));
                len  = frame_bytes(kind);
                wa   = 16'($urandom);
                case ($urandom_range(0, 15))
                    0: wa = 16'h0000;
                    1: wa = 16'hFFFF;
                    2, 3, 4: if (kind == swcfd_pkg::KIND_READY) wa = {5'($urandom), 11'd0};
                    default: ;
                endcase
                bad_word = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len / 3 - 1) : -1;
                len_used = ($urandom_range(0, 11) == 0) ? $urandom_range(1, len - 1) : len;
                send_frame(kind, wa, 16'($urandom), 16'($urandom), bad_word, len_used, 1'b1);
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        offer_byte(2'($urandom_range(0, 3)), 8'($urandom), 1'b0);
                    end
                end
            end
            if ($urandom_range(0, 299) == 0) begin
                drain_results();
            end
        end

        drain_results();
        if (sb.fail_count == 0) begin
            $display("** sensor_word_crc_frame_decoder: PASSED **");
        end else begin
            $display("** sensor_word_crc_frame_decoder: FAILED **");
        end
        $finish;
    end

endmodule
